[design/tcw_pkg.sv]
package tcw_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int MOVE_COUNT    = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int CROW_W        = $clog2(SCREEN_HEIGHT);

    // field widths
    localparam int FUNC_W = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int COLOR_W = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    // command codes
    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_BKSP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PUT_AT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SCR_UP  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SCR_DN  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd6;

    // configuration register indexes
    localparam logic REG_TEXT_COLOR  = 1'b0;
    localparam logic REG_BLANK_ENTRY = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } cmd_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_location;
        logic [CELL_W-1:0] cell_value;
    } res_t;

endpackage

[design/text_console_writer.sv]
// Cursor, put, backspace, read: execute state, then emit state with a registered result.
// Scroll (and a put that wraps on the bottom row) makes a single copy/fill walk
// over the screen memory, one cell per cycle.
// Clear: a fill walk over all cells. Requests are taken in idle or as a result goes out.
// Reset: synchronous active-low; afterwards a fill walk writes 0x0720 to
// every cell, no request is taken during it (config writes still are).
module text_console_writer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcw_pkg::cmd_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcw_pkg::res_t       m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_COPY, S_FILL, S_EMIT} state_t;

    localparam logic [ADDR_W-1:0] WIDTH_A   = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] MOVE_A    = ADDR_W'(MOVE_COUNT);
    localparam logic [ADDR_W-1:0] MOVE_LAST = ADDR_W'(MOVE_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_W_M1  = ADDR_W'(SCREEN_WIDTH - 1);
    localparam logic [CROW_W-1:0] ROW_LAST  = CROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W:0]    COLS_E    = (COL_W+1)'(SCREEN_WIDTH);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [CROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                copy_up_reg, copy_up_next;
    logic [ADDR_W-1:0]   fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0]   fill_end_reg, fill_end_next;
    logic [CELL_W-1:0]   fill_val_reg, fill_val_next;
    logic                fill_emit_reg, fill_emit_next;
    logic                hit_reg, hit_next;
    logic                m_valid_reg, m_valid_next;
    res_t                m_data_reg, m_data_next;
    logic [CELL_W-1:0]   rd_data_reg;
    logic [COLOR_W-1:0]  text_color_reg;
    logic [CELL_W-1:0]   blank_entry_reg;

    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr, src_addr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   cur_addr, pos_addr, cur_lin;
    logic [COL_W:0]      col_inc;
    logic                pos_ok, out_free;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= RESET_COLOR;
            blank_entry_reg <= RESET_CELL;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_TEXT_COLOR:  text_color_reg  <= pwdata[COLOR_W-1:0];
                REG_BLANK_ENTRY: blank_entry_reg <= pwdata[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEXT_COLOR:  prdata = {24'b0, text_color_reg};
            REG_BLANK_ENTRY: prdata = {16'b0, blank_entry_reg};
            default:         prdata = '0;
        endcase
    end

    // screen memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign cur_lin  = ADDR_W'(cur_row_reg) * WIDTH_A;
    assign cur_addr = cur_lin + ADDR_W'(cur_col_reg);
    assign pos_addr = ADDR_W'(cmd_reg.row) * WIDTH_A + ADDR_W'(cmd_reg.column);
    assign pos_ok   = (32'(cmd_reg.column) < SCREEN_WIDTH) &&
                      (32'(cmd_reg.row) < SCREEN_HEIGHT);
    assign col_inc  = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign out_free = !m_valid_reg || m_ready;
    assign src_addr = copy_up_reg ? (cnt_reg + WIDTH_A) : (MOVE_LAST - cnt_reg);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = wr_pend_reg;
        wr_addr_next   = wr_addr_reg;
        copy_up_next   = copy_up_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        fill_val_next  = fill_val_reg;
        fill_emit_next = fill_emit_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        s_ready        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                hit_next   = 1'b0;
                state_next = S_EMIT;
                case (cmd_reg.func)
                    FN_PUT: begin
                        if (cmd_reg.char_code != CH_NEWLINE) begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_addr;
                            mem_wdata = {text_color_reg, cmd_reg.char_code};
                        end
                        if (cmd_reg.char_code == CH_NEWLINE || col_inc == COLS_E) begin
                            cur_col_next = '0;
                            if (cur_row_reg == ROW_LAST) begin
                                // bottom row: move everything up a line
                                copy_up_next = 1'b1;
                                cnt_next     = '0;
                                wr_pend_next = 1'b0;
                                state_next   = S_COPY;
                            end else begin
                                cur_row_next = cur_row_reg + CROW_W'(1);
                            end
                        end else begin
                            cur_col_next = col_inc[COL_W-1:0];
                        end
                    end
                    FN_BKSP: begin
                        if (cur_col_reg != '0) begin
                            cur_col_next = cur_col_reg - COL_W'(1);
                            mem_we       = 1'b1;
                            mem_waddr    = cur_addr - ADDR_W'(1);
                            mem_wdata    = {text_color_reg, CH_SPACE};
                        end
                    end
                    FN_CLEAR: begin
                        cur_col_next   = '0;
                        cur_row_next   = '0;
                        fill_addr_next = '0;
                        fill_end_next  = LAST_A;
                        fill_val_next  = blank_entry_reg;
                        fill_emit_next = 1'b1;
                        state_next     = S_FILL;
                    end
                    FN_PUT_AT: begin
                        if (pos_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_addr;
                            mem_wdata = {text_color_reg, cmd_reg.char_code};
                        end
                    end
                    FN_SCR_UP: begin
                        // rows shift toward the bottom, top row blanked
                        copy_up_next = 1'b0;
                        cnt_next     = '0;
                        wr_pend_next = 1'b0;
                        state_next   = S_COPY;
                    end
                    FN_SCR_DN: begin
                        copy_up_next = 1'b1;
                        cnt_next     = '0;
                        wr_pend_next = 1'b0;
                        state_next   = S_COPY;
                    end
                    FN_READ: begin
                        if (pos_ok) begin
                            mem_re    = 1'b1;
                            mem_raddr = pos_addr;
                        end
                        hit_next = pos_ok;
                    end
                    default: ;
                endcase
            end

            S_COPY: begin
                // read one cell per cycle, write it back in the next cycle
                if (wr_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (cnt_reg != MOVE_A) begin
                    mem_re       = 1'b1;
                    mem_raddr    = src_addr;
                    wr_pend_next = 1'b1;
                    wr_addr_next = copy_up_reg ? cnt_reg : (src_addr + WIDTH_A);
                    cnt_next     = cnt_reg + ADDR_W'(1);
                end else begin
                    wr_pend_next   = 1'b0;
                    fill_addr_next = copy_up_reg ? MOVE_A : '0;
                    fill_end_next  = copy_up_reg ? LAST_A : ROW_W_M1;
                    fill_val_next  = {text_color_reg, CH_SPACE};
                    fill_emit_next = 1'b1;
                    state_next     = S_FILL;
                end
            end

            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = fill_val_reg;
                if (fill_addr_reg == fill_end_reg) begin
                    state_next = fill_emit_reg ? S_EMIT : S_IDLE;
                end else begin
                    fill_addr_next = fill_addr_reg + ADDR_W'(1);
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.cursor_location = LOC_W'(cur_addr);
                    m_data_next.cell_value      = hit_reg ? rd_data_reg : '0;
                    s_ready                     = 1'b1;
                    if (s_valid) begin
                        cmd_next   = s_data;
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_FILL;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            copy_up_reg   <= 1'b0;
            fill_addr_reg <= '0;
            fill_end_reg  <= LAST_A;
            fill_val_reg  <= RESET_CELL;
            fill_emit_reg <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cnt_reg       <= cnt_next;
            wr_pend_reg   <= wr_pend_next;
            copy_up_reg   <= copy_up_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            fill_val_reg  <= fill_val_next;
            fill_emit_reg <= fill_emit_next;
            hit_reg       <= hit_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        wr_addr_reg <= wr_addr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_no_req_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FILL |-> !s_ready)
        else $error("request taken during fill walk");

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (32'(mem_waddr) < CELL_COUNT))
        else $error("screen write outside memory");

    a_cursor_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_row_reg) < SCREEN_HEIGHT) && (32'(cur_col_reg) < SCREEN_WIDTH))
        else $error("cursor outside screen");

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_EXEC)
        else $error("accepted request not executed");
`endif

endmodule

[verif/tb_text_console_writer.sv]
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;
    localparam int     RESET_CYCLES  = 12;
    // a full copy/fill walk plus margin
    localparam int     SETTLE_CYCLES = CELL_COUNT + 2 * SCREEN_WIDTH;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint CYCLE_LIMIT   = 20_000_000;
    localparam int     PRINT_LIMIT   = 100;

    localparam logic [2:0] ADDR_TEXT_COLOR  = {REG_TEXT_COLOR, 2'b00};
    localparam logic [2:0] ADDR_BLANK_ENTRY = {REG_BLANK_ENTRY, 2'b00};

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    cmd_t        s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    res_t        m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_writer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    // console shadow: screen, cursor and registers
    logic [CELL_W-1:0]  screen_model [CELL_COUNT];
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [COLOR_W-1:0] color_reg;
    logic [CELL_W-1:0]  blank_reg;
    res_t               expected_q [$];

    int     errors         = 0;
    int     items_sent     = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_req       = 0;
    int     hold_seen      = 0;
    int     hold_left      = 0;
    longint cycle_count    = 0;

    function automatic logic [CELL_W-1:0] attr_cell(logic [CHAR_W-1:0] ch);
        return {color_reg, ch};
    endfunction

    function automatic void blank_row(int unsigned r);
        for (int x = 0; x < SCREEN_WIDTH; x++)
            screen_model[r * SCREEN_WIDTH + x] = attr_cell(CH_SPACE);
    endfunction

    // content moves toward row 0, bottom row blanked
    function automatic void rows_toward_top();
        for (int i = 0; i < MOVE_COUNT; i++)
            screen_model[i] = screen_model[i + SCREEN_WIDTH];
        blank_row(SCREEN_HEIGHT - 1);
    endfunction

    // content moves toward the bottom, row 0 blanked
    function automatic void rows_toward_bottom();
        for (int i = MOVE_COUNT - 1; i >= 0; i--)
            screen_model[i + SCREEN_WIDTH] = screen_model[i];
        blank_row(0);
    endfunction

    function automatic res_t console_step(cmd_t c);
        res_t r;
        logic on_screen;
        int   pos;
        on_screen = (c.column < SCREEN_WIDTH) && (c.row < SCREEN_HEIGHT);
        pos = int'(c.row) * SCREEN_WIDTH + int'(c.column);
        r.cell_value = '0;
        case (c.func)
            FN_PUT: begin
                if (c.char_code != CH_NEWLINE)
                    screen_model[cur_row * SCREEN_WIDTH + cur_col] = attr_cell(c.char_code);
                cur_col++;
                if (cur_col >= SCREEN_WIDTH || c.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    if (cur_row + 1 >= SCREEN_HEIGHT)
                        rows_toward_top();
                    else
                        cur_row++;
                end
            end
            FN_BKSP: begin
                if (cur_col != 0) begin
                    cur_col--;
                    screen_model[cur_row * SCREEN_WIDTH + cur_col] = attr_cell(CH_SPACE);
                end
            end
            FN_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = blank_reg;
                cur_col = 0;
                cur_row = 0;
            end
            FN_PUT_AT: begin
                if (on_screen)
                    screen_model[pos] = attr_cell(c.char_code);
            end
            FN_SCR_UP: rows_toward_bottom();
            FN_SCR_DN: rows_toward_top();
            FN_READ: begin
                if (on_screen)
                    r.cell_value = screen_model[pos];
            end
            default: ;
        endcase
        r.cursor_location = LOC_W'(cur_row * SCREEN_WIDTH + cur_col);
        return r;
    endfunction

    function automatic cmd_t mk_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
                                    int col, int row);
        cmd_t c;
        c.func      = f;
        c.char_code = ch;
        c.column    = COL_W'(col);
        c.row       = ROW_W'(row);
        return c;
    endfunction

    // cursor commands ignore column/row, so those fields get any value
    function automatic cmd_t cursor_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch);
        return mk_cmd(f, ch, $urandom_range(0, 127), $urandom_range(0, 31));
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        if ($urandom_range(0, 99) < 85)
            return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        errors++;
    endtask

    task automatic send_cmd(cmd_t c);
        int gap;
        @(negedge aclk);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = c;
        do @(posedge aclk); while (!s_ready);
        expected_q.push_back(console_step(c));
        items_sent++;
    endtask

    task automatic wait_drain(int settle);
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_TEXT_COLOR)
            color_reg = data[COLOR_W-1:0];
        else
            blank_reg = data[CELL_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", int'(m_data), 0);
            end else begin
                want = expected_q.pop_front();
                if (m_data.cursor_location !== want.cursor_location)
                    report_mismatch("cursor_location", int'(m_data.cursor_location),
                                    int'(want.cursor_location));
                if (m_data.cell_value !== want.cell_value)
                    report_mismatch("cell_value", int'(m_data.cell_value),
                                    int'(want.cell_value));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed_commands();
        send_cmd(mk_cmd(FN_READ, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_PUT, 8'h48, 0, 0));
        send_cmd(mk_cmd(FN_PUT, 8'h00, 127, 31));
        send_cmd(mk_cmd(FN_PUT, 8'hFF, 0, 0));
        send_cmd(mk_cmd(FN_BKSP, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_PUT, CH_NEWLINE, 0, 0));
        send_cmd(mk_cmd(FN_BKSP, 8'hFF, 127, 31));   // column zero: no change
        send_cmd(mk_cmd(FN_PUT_AT, 8'hFF, 79, 24));
        send_cmd(mk_cmd(FN_READ, 8'h00, 79, 24));
        // positions off the screen are ignored / read back zero
        send_cmd(mk_cmd(FN_PUT_AT, 8'h41, 80, 0));
        send_cmd(mk_cmd(FN_PUT_AT, 8'h41, 0, 25));
        send_cmd(mk_cmd(FN_PUT_AT, 8'h41, 127, 31));
        send_cmd(mk_cmd(FN_READ, 8'h00, 127, 31));
        send_cmd(mk_cmd(FN_READ, 8'h00, 80, 0));
        send_cmd(mk_cmd(FN_READ, 8'h00, 0, 25));
        send_cmd(mk_cmd(FN_READ, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_SCR_UP, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_READ, 8'h00, 0, 1));
        send_cmd(mk_cmd(FN_SCR_DN, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_READ, 8'h00, 79, 24));
        send_cmd(mk_cmd(FN_NOP, 8'hFF, 127, 31));
        send_cmd(mk_cmd(FN_CLEAR, 8'h00, 0, 0));
        send_cmd(mk_cmd(FN_READ, 8'h00, 40, 12));
        send_cmd(mk_cmd(FN_PUT, 8'h7F, 0, 0));
        send_cmd(mk_cmd(FN_READ, 8'h00, 0, 0));
    endtask

    task automatic test_output_backpressure();
        wait_drain(0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 40; i++) begin
            if (i % 5 == 4)
                send_cmd(mk_cmd(FN_READ, 8'h00, $urandom_range(0, 79), $urandom_range(0, 24)));
            else
                send_cmd(cursor_cmd(FN_PUT, text_char()));
        end
        // wait for every result to drain before going on
        wait_drain(0);
    endtask

    task automatic random_episode();
        int kind;
        int len;
        int col;
        int row;
        logic [CHAR_W-1:0] ch;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
                send_cmd(cursor_cmd(FN_PUT, text_char()));
            if ($urandom_range(0, 4) != 0)
                send_cmd(cursor_cmd(FN_PUT, CH_NEWLINE));
        end else if (kind < 62) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_cmd(cursor_cmd(FN_BKSP, CHAR_W'($urandom_range(0, 255))));
        end else if (kind < 80) begin
            if ($urandom_range(0, 9) == 0) begin
                col = $urandom_range(0, 127);
                row = $urandom_range(0, 31);
            end else begin
                col = $urandom_range(0, SCREEN_WIDTH - 1);
                row = $urandom_range(0, SCREEN_HEIGHT - 1);
            end
            ch = CHAR_W'($urandom_range(0, 255));
            send_cmd(mk_cmd(FN_PUT_AT, ch, col, row));
            send_cmd(mk_cmd(FN_READ, CHAR_W'($urandom_range(0, 255)), col, row));
        end else if (kind < 86) begin
            send_cmd(cursor_cmd($urandom_range(0, 1) ? FN_SCR_UP : FN_SCR_DN,
                                CHAR_W'($urandom_range(0, 255))));
        end else if (kind < 94) begin
            send_cmd(mk_cmd(FN_READ, 8'h00, $urandom_range(0, SCREEN_WIDTH - 1),
                            $urandom_range(0, SCREEN_HEIGHT - 1)));
            send_cmd(cursor_cmd(FN_NOP, CHAR_W'($urandom_range(0, 255))));
        end else if (kind < 96) begin
            send_cmd(cursor_cmd(FN_CLEAR, CHAR_W'($urandom_range(0, 255))));
        end else if (kind < 99) begin
            send_cmd(cmd_t'($bits(cmd_t)'($urandom)));
        end else begin
            wait_drain(0);
        end
    endtask

    task automatic test_random_traffic(int idle_s, int stall_r, logic [COLOR_W-1:0] color,
                                       logic [CELL_W-1:0] blank, int quota);
        int target;
        wait_drain(SETTLE_CYCLES);
        apb_write(ADDR_TEXT_COLOR, 32'(color));
        apb_write(ADDR_BLANK_ENTRY, 32'(blank));
        send_idle_pct  = idle_s;
        recv_stall_pct = stall_r;
        target = items_sent + quota;
        while (items_sent < target)
            random_episode();
    endtask

    initial begin
        for (int i = 0; i < CELL_COUNT; i++)
            screen_model[i] = RESET_CELL;
        cur_col   = 0;
        cur_row   = 0;
        color_reg = RESET_COLOR;
        blank_reg = RESET_CELL;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        test_directed_commands();
        test_output_backpressure();
        test_random_traffic(0, 0, 8'h00, 16'h0000, 330);
        test_random_traffic(53, 0, 8'hFF, 16'hFFFF, 330);
        test_random_traffic(0, 53, COLOR_W'($urandom), CELL_W'($urandom), 330);
        test_random_traffic(24, 24, COLOR_W'($urandom), CELL_W'($urandom), 330);
        wait_drain(SETTLE_CYCLES);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
